// ----- rtl/apsp_pkg.sv -----
package apsp_pkg;

  // Fixed field widths of the channels
  localparam int WEIGHT_W   = 16;
  localparam int IDX_OUT_W  = 3;
  localparam int CFG_W      = 4;

  // node_count after reset
  localparam logic [CFG_W-1:0] NODE_COUNT_RST = 4'd8;

  // weight code for "no edge"
  localparam logic signed [WEIGHT_W-1:0] NO_EDGE = -16'sd1;

endpackage

// ----- rtl/apsp_if.sv -----
interface apsp_in_if;
  logic                                      valid;
  logic                                      ready;
  logic signed [apsp_pkg::WEIGHT_W-1:0]      weight;

  modport source (output valid, output weight, input ready);
  modport sink   (input valid, input weight, output ready);
endinterface

interface apsp_out_if #(
  parameter int DIST_BITS = 21
);
  logic                                valid;
  logic                                ready;
  logic [apsp_pkg::IDX_OUT_W-1:0]      row_index;
  logic [apsp_pkg::IDX_OUT_W-1:0]      col_index;
  logic signed [DIST_BITS-1:0]         distance;
  logic                                reachable;
  logic                                negative_cycle;
  logic                                last_result;

  modport source (output valid, output row_index, output col_index, output distance,
                  output reachable, output negative_cycle, output last_result,
                  input ready);
  modport sink   (input valid, input row_index, input col_index, input distance,
                  input reachable, input negative_cycle, input last_result,
                  output ready);
endinterface

// ----- rtl/all_pairs_shortest_path_unit.sv -----
// Floyd-Warshall all-pairs shortest path unit. Weights of an N x N adjacency
// matrix (N = node_count, clamped to 1..MAX_NODES) are loaded one word per
// cycle in row-major order; -1 means no edge and the diagonal is taken as zero.
// The word that completes the matrix starts relaxation, which runs on a single
// shared add/saturate/compare unit against a distance memory with two read
// ports and one write port: for each (k, i) pair d[i][k] is read and then
// latched, and each (k, i, j) step reads d[k][j] and d[i][j], then compares
// and writes back; rows with d[i][k] unreachable skip their j loop. The N^2
// results then leave one at a time, each read from memory and then handed to
// the output register, more slowly under back-pressure. The input is not
// ready from the completing word until the last result has been loaded into
// the output register. A write to node_count restarts the load at entry 0
// and must happen only while the unit is idle.
module all_pairs_shortest_path_unit #(
  parameter int MAX_NODES = 8,
  parameter int DIST_BITS = 21
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [apsp_pkg::CFG_W-1:0]   cfg_wdata_i,
  apsp_in_if.sink                      in_i,
  apsp_out_if.source                   out_o
);

  localparam int IDX_W  = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int ADDR_W = 2 * IDX_W;
  localparam int DEPTH  = 1 << ADDR_W;
  localparam int ENT_W  = DIST_BITS + 1;   // {reach, dist}
  localparam logic [apsp_pkg::CFG_W-1:0] MAX_N = apsp_pkg::CFG_W'(MAX_NODES);

  localparam logic signed [DIST_BITS-1:0] DIST_MAX = {1'b0, {(DIST_BITS-1){1'b1}}};
  localparam logic signed [DIST_BITS-1:0] DIST_MIN = {1'b1, {(DIST_BITS-1){1'b0}}};

  typedef enum logic [2:0] {
    S_LOAD,     // taking weight words
    S_IK_RD,    // fetch d[i][k]
    S_IK_CAP,   // latch d[i][k], skip row if unreachable
    S_J_RD,     // fetch d[k][j] and d[i][j]
    S_J_WR,     // relax d[i][j]
    S_EM_RD,    // fetch result entry
    S_EM_OUT    // hand entry to output register
  } state_e;

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  state_e                        state_q, state_d;
  logic [apsp_pkg::CFG_W-1:0]    nc_q, nc_d;
  logic [IDX_W-1:0]              row_q, row_d;   // load row / i / emit row
  logic [IDX_W-1:0]              col_q, col_d;   // load col / j / emit col
  logic [IDX_W-1:0]              k_q, k_d;
  logic [ENT_W-1:0]              ik_q, ik_d;     // live copy of d[i][k]
  logic                          neg_q, neg_d;

  logic                          out_valid_q, out_valid_d;
  logic [apsp_pkg::IDX_OUT_W-1:0] out_row_q, out_row_d;
  logic [apsp_pkg::IDX_OUT_W-1:0] out_col_q, out_col_d;
  logic signed [DIST_BITS-1:0]   out_dist_q, out_dist_d;
  logic                          out_reach_q, out_reach_d;
  logic                          out_neg_q, out_neg_d;
  logic                          out_last_q, out_last_d;

  // Distance memory: bit DIST_BITS is reach, low bits the distance.
  // Entries are always written by a load before any read of them.
  logic [ENT_W-1:0]              mem_q [DEPTH];
  logic [ENT_W-1:0]              rd_a_q, rd_b_q;

  logic                          rd_en;
  logic [ADDR_W-1:0]             rd_a_addr, rd_b_addr;
  logic                          wr_en;
  logic [ADDR_W-1:0]             wr_addr;
  logic [ENT_W-1:0]              wr_data;

  // ---------------------------------------------------------------------------
  // Side length and counter end tests
  // ---------------------------------------------------------------------------
  logic [apsp_pkg::CFG_W-1:0]    side, side_last;
  logic                          row_last, col_last, k_last;

  always_comb begin
    if (nc_q == '0) begin
      side = apsp_pkg::CFG_W'(1);
    end else if (nc_q > MAX_N) begin
      side = MAX_N;
    end else begin
      side = nc_q;
    end
  end

  assign side_last = side - apsp_pkg::CFG_W'(1);
  assign row_last  = (apsp_pkg::CFG_W'(row_q) == side_last);
  assign col_last  = (apsp_pkg::CFG_W'(col_q) == side_last);
  assign k_last    = (apsp_pkg::CFG_W'(k_q)   == side_last);

  // ---------------------------------------------------------------------------
  // Shared relax unit: saturating add of d[i][k] + d[k][j], compare to d[i][j]
  // ---------------------------------------------------------------------------
  logic signed [DIST_BITS-1:0]   ik_dist, kj_dist, ij_dist;
  logic                          kj_reach, ij_reach;
  logic signed [DIST_BITS:0]     sum_w;
  logic signed [DIST_BITS-1:0]   sum_sat;
  logic                          relax_upd;

  assign ik_dist  = $signed(ik_q[DIST_BITS-1:0]);
  assign kj_dist  = $signed(rd_a_q[DIST_BITS-1:0]);
  assign kj_reach = rd_a_q[DIST_BITS];
  assign ij_dist  = $signed(rd_b_q[DIST_BITS-1:0]);
  assign ij_reach = rd_b_q[DIST_BITS];

  assign sum_w = $signed({ik_dist[DIST_BITS-1], ik_dist})
               + $signed({kj_dist[DIST_BITS-1], kj_dist});

  always_comb begin
    if (sum_w[DIST_BITS] != sum_w[DIST_BITS-1]) begin
      sum_sat = sum_w[DIST_BITS] ? DIST_MIN : DIST_MAX;
    end else begin
      sum_sat = $signed(sum_w[DIST_BITS-1:0]);
    end
  end

  // d[i][k] is known reachable here; the row is skipped otherwise
  assign relax_upd = kj_reach && (!ij_reach || (sum_sat < ij_dist));

  // ---------------------------------------------------------------------------
  // Load word decode
  // ---------------------------------------------------------------------------
  logic                          in_accept;
  logic                          out_take;
  logic [ENT_W-1:0]              load_ent;

  assign in_i.ready = (state_q == S_LOAD);
  assign in_accept  = in_i.valid && in_i.ready;
  assign out_take   = out_valid_q && out_o.ready;

  always_comb begin
    if (row_q == col_q) begin
      load_ent = {1'b1, {DIST_BITS{1'b0}}};
    end else if (in_i.weight == apsp_pkg::NO_EDGE) begin
      load_ent = '0;
    end else begin
      load_ent = {1'b1, DIST_BITS'(in_i.weight)};
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d     = state_q;
    nc_d        = nc_q;
    row_d       = row_q;
    col_d       = col_q;
    k_d         = k_q;
    ik_d        = ik_q;
    neg_d       = neg_q;
    out_valid_d = out_valid_q;
    out_row_d   = out_row_q;
    out_col_d   = out_col_q;
    out_dist_d  = out_dist_q;
    out_reach_d = out_reach_q;
    out_neg_d   = out_neg_q;
    out_last_d  = out_last_q;

    rd_en     = 1'b0;
    rd_a_addr = {row_q, col_q};
    rd_b_addr = {row_q, col_q};
    wr_en     = 1'b0;
    wr_addr   = {row_q, col_q};
    wr_data   = load_ent;

    if (out_take) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_LOAD: begin
        if (in_accept) begin
          wr_en = 1'b1;
          if (col_last) begin
            col_d = '0;
            if (row_last) begin
              // matrix complete: start relaxation at k = 0, i = 0
              row_d   = '0;
              k_d     = '0;
              neg_d   = 1'b0;
              state_d = S_IK_RD;
            end else begin
              row_d = row_q + IDX_W'(1);
            end
          end else begin
            col_d = col_q + IDX_W'(1);
          end
        end
      end

      S_IK_RD: begin
        rd_en     = 1'b1;
        rd_a_addr = {row_q, k_q};
        state_d   = S_IK_CAP;
      end

      S_IK_CAP: begin
        ik_d  = rd_a_q;
        col_d = '0;
        if (rd_a_q[DIST_BITS]) begin
          state_d = S_J_RD;
        end else if (row_last) begin
          row_d = '0;
          if (k_last) begin
            state_d = S_EM_RD;
          end else begin
            k_d     = k_q + IDX_W'(1);
            state_d = S_IK_RD;
          end
        end else begin
          row_d   = row_q + IDX_W'(1);
          state_d = S_IK_RD;
        end
      end

      S_J_RD: begin
        rd_en     = 1'b1;
        rd_a_addr = {k_q, col_q};
        rd_b_addr = {row_q, col_q};
        state_d   = S_J_WR;
      end

      S_J_WR: begin
        if (relax_upd) begin
          wr_en   = 1'b1;
          wr_data = {1'b1, sum_sat};
          // j == k rewrites d[i][k] itself; keep the live copy in step
          if (col_q == k_q) begin
            ik_d = {1'b1, sum_sat};
          end
          // diagonals only ever decrease, so one negative write marks the cycle
          if ((row_q == col_q) && sum_sat[DIST_BITS-1]) begin
            neg_d = 1'b1;
          end
        end
        if (col_last) begin
          col_d = '0;
          if (row_last) begin
            row_d = '0;
            if (k_last) begin
              state_d = S_EM_RD;
            end else begin
              k_d     = k_q + IDX_W'(1);
              state_d = S_IK_RD;
            end
          end else begin
            row_d   = row_q + IDX_W'(1);
            state_d = S_IK_RD;
          end
        end else begin
          col_d   = col_q + IDX_W'(1);
          state_d = S_J_RD;
        end
      end

      S_EM_RD: begin
        rd_en     = 1'b1;
        rd_a_addr = {row_q, col_q};
        state_d   = S_EM_OUT;
      end

      S_EM_OUT: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          out_row_d   = apsp_pkg::IDX_OUT_W'(row_q);
          out_col_d   = apsp_pkg::IDX_OUT_W'(col_q);
          out_neg_d   = neg_q;
          out_last_d  = row_last && col_last;
          // diagonal always reads as reachable at zero; unreachable reads zero
          if (row_q == col_q) begin
            out_reach_d = 1'b1;
            out_dist_d  = '0;
          end else begin
            out_reach_d = rd_a_q[DIST_BITS];
            out_dist_d  = rd_a_q[DIST_BITS] ? $signed(rd_a_q[DIST_BITS-1:0]) : '0;
          end
          if (col_last) begin
            col_d = '0;
            if (row_last) begin
              row_d   = '0;
              state_d = S_LOAD;
            end else begin
              row_d   = row_q + IDX_W'(1);
              state_d = S_EM_RD;
            end
          end else begin
            col_d   = col_q + IDX_W'(1);
            state_d = S_EM_RD;
          end
        end
      end

      default: state_d = S_LOAD;
    endcase

    // register write: new side, load restarts at entry 0
    if (cfg_we_i) begin
      nc_d  = cfg_wdata_i;
      row_d = '0;
      col_d = '0;
      k_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_LOAD;
      nc_q        <= apsp_pkg::NODE_COUNT_RST;
      row_q       <= '0;
      col_q       <= '0;
      k_q         <= '0;
      neg_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      nc_q        <= nc_d;
      row_q       <= row_d;
      col_q       <= col_d;
      k_q         <= k_d;
      neg_q       <= neg_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    ik_q        <= ik_d;
    out_row_q   <= out_row_d;
    out_col_q   <= out_col_d;
    out_dist_q  <= out_dist_d;
    out_reach_q <= out_reach_d;
    out_neg_q   <= out_neg_d;
    out_last_q  <= out_last_d;
  end

  // distance memory: one write port, two registered read ports
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_a_q <= mem_q[rd_a_addr];
      rd_b_q <= mem_q[rd_b_addr];
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.row_index      = out_row_q;
  assign out_o.col_index      = out_col_q;
  assign out_o.distance       = out_dist_q;
  assign out_o.reachable      = out_reach_q;
  assign out_o.negative_cycle = out_neg_q;
  assign out_o.last_result    = out_last_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // counters stay inside the active matrix
  a_idx_in_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (apsp_pkg::CFG_W'(row_q) <= side_last) && (apsp_pkg::CFG_W'(col_q) <= side_last)
    && (apsp_pkg::CFG_W'(k_q) <= side_last))
    else $error("matrix index beyond side length");

  // the final result sits on the last diagonal entry
  a_last_on_diag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.last_result) |->
      (out_o.row_index == out_o.col_index))
    else $error("last result off the diagonal");

  // diagonal results are reachable at zero
  a_diag_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && (out_o.row_index == out_o.col_index)) |->
      (out_o.reachable && (out_o.distance == '0)))
    else $error("diagonal result not zero");

  // relax write-back only from the compare state or a load word
  a_write_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> ((state_q == S_J_WR) || in_accept))
    else $error("distance memory written outside load or relax");

endmodule
